FILE: src/tvn_pkg.sv
// Package for the two-octave value noise block: hash constants, fixed-point
// constants and configuration register codes.
// No dependencies.
package tvn_pkg;

  // Configuration register codes
  typedef enum logic [0:0] {
    REG_INVERSE_SCALE = 1'b0,
    REG_NOISE_SEED    = 1'b1
  } cfg_reg_t;

  localparam int unsigned DEF_FRACTION_BITS = 16;

  localparam logic [31:0] INV_SCALE_RST = 32'd1398101;
  localparam logic [31:0] SEED_RST      = 32'd0;

  // Corner hash multipliers
  localparam logic [31:0] HASH_MUL_X    = 32'h9E3779B1;
  localparam logic [31:0] HASH_MUL_Z    = 32'h85EBCA77;
  localparam logic [31:0] HASH_MUL_SEED = 32'hC2B2AE3D;
  localparam logic [31:0] HASH_MIX_A    = 32'h2C1B3C6D;
  localparam logic [31:0] HASH_MIX_B    = 32'h297A2D39;

  // Second octave: 2.3 in Q2.30 and its seed flip
  localparam logic [31:0] OCTAVE_MUL      = 32'd2469606195;
  localparam logic [31:0] OCTAVE_SEED_XOR = 32'h5BD1E995;

  // floor(m / 3) = (m * DIV3_MAGIC) >> DIV3_SHIFT for m < 2^18
  localparam int unsigned DIV3_SHIFT = 20;
  localparam logic [18:0] DIV3_MAGIC = 19'd349526;

endpackage

FILE: src/two_octave_value_noise.sv
// Two-octave 2D value noise: eleven-stage pipeline from world position to
// clump value. Depends on tvn_pkg.
//
// The result of an accepted input is registered in the last stage and is
// shown on out_noise_value while out_valid is high.
// Throughput: one item per cycle; each stage holds only while the stage
// after it is full and stalled, so bubbles close up under backpressure.
// Reset (synchronous, rst_n low): all stage valid bits clear, inverse_scale
// returns to one twelfth and noise_seed to zero.
module two_octave_value_noise
  import tvn_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_world_x,
  input  logic signed [31:0] in_world_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [15:0] out_noise_value,
  input  logic               cfg_wr_en,
  input  logic        [0:0]  cfg_index,
  input  logic        [31:0] cfg_wr_data
);

  localparam int unsigned F      = FRACTION_BITS;
  localparam int unsigned NSTAGE = 11;
  localparam logic [F:0]   ONE       = (F+1)'(1) << F;
  localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [31:0] inverse_scale_r;
  logic [31:0] noise_seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inverse_scale_r <= INV_SCALE_RST;
      noise_seed_r    <= SEED_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_INVERSE_SCALE: inverse_scale_r <= cfg_wr_data;
        REG_NOISE_SEED:    noise_seed_r    <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or drains
  // ---------------------------------------------------------------
  logic [NSTAGE:1]   v_r;
  logic [NSTAGE+1:1] en;

  always_comb begin
    en[NSTAGE+1] = out_ready;
    for (int k = NSTAGE; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v_r[NSTAGE];

  // ---------------------------------------------------------------
  // Stage 1: position times reciprocal scale, floor to Q.32
  // ---------------------------------------------------------------
  logic signed [64:0] prod_x, prod_z;
  logic [63:0] g1x_r, g1z_r;

  assign prod_x = in_world_x * $signed({1'b0, inverse_scale_r});
  assign prod_z = in_world_z * $signed({1'b0, inverse_scale_r});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      g1x_r <= {{8{prod_x[63]}}, prod_x[63:8]};
      g1z_r <= {{8{prod_z[63]}}, prod_z[63:8]};
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: partial products of the 2.3x octave scaling
  // ---------------------------------------------------------------
  logic [63:0] hk_x, hk_z;
  logic [61:0] hik_x_r, hik_z_r;
  logic [63:0] lok_x_r, lok_z_r;
  logic [63:0] g2x_r, g2z_r;

  assign hk_x = g1x_r[63:32] * OCTAVE_MUL;
  assign hk_z = g1z_r[63:32] * OCTAVE_MUL;

  // Correct the unsigned high product for a negative integer part
  always_ff @(posedge clk) begin
    if (en[2]) begin
      hik_x_r <= hk_x[61:0] - (g1x_r[63] ? {OCTAVE_MUL[29:0], 32'd0} : 62'd0);
      hik_z_r <= hk_z[61:0] - (g1z_r[63] ? {OCTAVE_MUL[29:0], 32'd0} : 62'd0);
      lok_x_r <= g1x_r[31:0] * OCTAVE_MUL;
      lok_z_r <= g1z_r[31:0] * OCTAVE_MUL;
      g2x_r   <= g1x_r;
      g2z_r   <= g1z_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: sum the octave coordinate; lane 0 base, lane 1 detail
  // ---------------------------------------------------------------
  logic [63:0] crd_x_r [2];
  logic [63:0] crd_z_r [2];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      crd_x_r[0] <= g2x_r;
      crd_z_r[0] <= g2z_r;
      crd_x_r[1] <= {hik_x_r, 2'b00} + {30'd0, lok_x_r[63:30]};
      crd_z_r[1] <= {hik_z_r, 2'b00} + {30'd0, lok_z_r[63:30]};
    end
  end

  // ---------------------------------------------------------------
  // Stages 4 to 10, one lane per octave
  // ---------------------------------------------------------------
  logic [31:0]     ax0_r [2];
  logic [31:0]     az0_r [2];
  logic [31:0]     sd_r  [2];
  logic [F-1:0]    tx_r  [2];
  logic [F-1:0]    tz_r  [2];
  logic [F-1:0]    t2x_r [2];
  logic [F-1:0]    t2z_r [2];
  logic [31:0]     h1_r  [2][4];
  logic [31:0]     h2_r  [2][4];
  logic [F:0]      sx5_r [2];
  logic [F:0]      sz5_r [2];
  logic [F:0]      sx6_r [2];
  logic [F:0]      sz6_r [2];
  logic [F:0]      sz7_r [2];
  logic [F:0]      sz8_r [2];
  logic [24+F:0]   p_r   [2][4];
  logic [23:0]     a_r   [2];
  logic [23:0]     b_r   [2];
  logic [24+F:0]   q0_r  [2];
  logic [24+F:0]   q1_r  [2];
  logic [23:0]     nval  [2];

  for (genvar o = 0; o < 2; o++) begin : g_oct
    logic [31:0]    seed_o;
    logic [31:0]    ax1;
    logic [31:0]    az1;
    logic [F-1:0]   tx, tz;
    logic [2*F-1:0] ttx, ttz;
    logic [F+1:0]   wx, wz;
    logic [2*F+1:0] ssx, ssz;

    // Stage 4: lattice row/column terms, seed term, squared fraction
    assign seed_o = (o == 0) ? noise_seed_r : (noise_seed_r ^ OCTAVE_SEED_XOR);
    assign tx  = crd_x_r[o][31 -: F];
    assign tz  = crd_z_r[o][31 -: F];
    assign ttx = tx * tx;
    assign ttz = tz * tz;

    always_ff @(posedge clk) begin
      if (en[4]) begin
        ax0_r[o] <= crd_x_r[o][63:32] * HASH_MUL_X;
        az0_r[o] <= crd_z_r[o][63:32] * HASH_MUL_Z;
        sd_r[o]  <= seed_o * HASH_MUL_SEED;
        tx_r[o]  <= tx;
        tz_r[o]  <= tz;
        t2x_r[o] <= ttx[2*F-1:F];
        t2z_r[o] <= ttz[2*F-1:F];
      end
    end

    // Stage 5: combine corner terms, first mix multiply; smoothstep
    assign ax1 = ax0_r[o] + HASH_MUL_X;
    assign az1 = az0_r[o] + HASH_MUL_Z;
    assign wx  = THREE_ONE - {1'b0, tx_r[o], 1'b0};
    assign wz  = THREE_ONE - {1'b0, tz_r[o], 1'b0};
    assign ssx = t2x_r[o] * wx;
    assign ssz = t2z_r[o] * wz;

    for (genvar c = 0; c < 4; c++) begin : g_corner
      logic [31:0] hm, hs, h2x, h3;
      logic [23:0] vv;

      // Corner c: bit 0 picks x + 1, bit 1 picks z + 1
      assign hm = ((c % 2 == 1) ? ax1 : ax0_r[o]) ^
                  ((c / 2 == 1) ? az1 : az0_r[o]) ^ sd_r[o];
      assign hs = hm ^ (hm >> 15);

      always_ff @(posedge clk) begin
        if (en[5]) h1_r[o][c] <= hs * HASH_MIX_A;
      end

      // Stage 6: second mix multiply
      assign h2x = h1_r[o][c] ^ (h1_r[o][c] >> 12);

      always_ff @(posedge clk) begin
        if (en[6]) h2_r[o][c] <= h2x * HASH_MIX_B;
      end

      // Stage 7: final xorshift, weight the corner value along x
      assign h3 = h2_r[o][c] ^ (h2_r[o][c] >> 15);
      assign vv = h3[31:8];

      always_ff @(posedge clk) begin
        if (en[7]) begin
          p_r[o][c] <= vv * ((c % 2 == 1) ? sx6_r[o] : (ONE - sx6_r[o]));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[5]) begin
        sx5_r[o] <= ssx[2*F:F];
        sz5_r[o] <= ssz[2*F:F];
      end
      if (en[6]) begin
        sx6_r[o] <= sx5_r[o];
        sz6_r[o] <= sz5_r[o];
      end
      if (en[7]) sz7_r[o] <= sz6_r[o];
    end

    // Stage 8: finish the two x lerps
    logic [25+F:0] sum_a, sum_b;
    assign sum_a = p_r[o][0] + p_r[o][1];
    assign sum_b = p_r[o][2] + p_r[o][3];

    always_ff @(posedge clk) begin
      if (en[8]) begin
        a_r[o]   <= sum_a[F+23:F];
        b_r[o]   <= sum_b[F+23:F];
        sz8_r[o] <= sz7_r[o];
      end
    end

    // Stage 9: weight the rows along z
    always_ff @(posedge clk) begin
      if (en[9]) begin
        q0_r[o] <= a_r[o] * (ONE - sz8_r[o]);
        q1_r[o] <= b_r[o] * sz8_r[o];
      end
    end

    // Stage 10 input: finish the z lerp
    logic [25+F:0] sum_q;
    assign sum_q   = q0_r[o] + q1_r[o];
    assign nval[o] = sum_q[F+23:F];
  end

  // ---------------------------------------------------------------
  // Stage 10: blend 2:1 and drop the low byte of the /768
  // ---------------------------------------------------------------
  logic [25:0] blend;
  logic [17:0] m_r;

  assign blend = {1'b0, nval[0], 1'b0} + {2'b00, nval[1]};

  always_ff @(posedge clk) begin
    if (en[10]) m_r <= blend[25:8];
  end

  // ---------------------------------------------------------------
  // Stage 11: divide by three, saturate, hold the result
  // ---------------------------------------------------------------
  logic [36:0] dprod;
  logic [16:0] quo;
  logic [15:0] out_noise_value_r;

  assign dprod = m_r * DIV3_MAGIC;
  assign quo   = dprod[DIV3_SHIFT+16:DIV3_SHIFT];

  always_ff @(posedge clk) begin
    if (en[11]) out_noise_value_r <= quo[16] ? 16'hFFFF : quo[15:0];
  end

  assign out_noise_value = out_noise_value_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output side is ready");

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("input stalled with a bubble in the pipeline");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[1])
    else $error("accepted item did not enter stage one");

  a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NSTAGE] && !out_ready) |=> (v_r[NSTAGE] && $stable(out_noise_value_r)))
    else $error("stalled result dropped or changed");

endmodule
